FILE: hw/rtl/mtat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtat_pkg;

  // fixed field widths
  localparam int ANGLE_W    = 15;
  localparam int TOTAL_W    = 22;
  localparam int LIFT_W     = 32;
  localparam int DESTROY_W  = 21;
  localparam int RATE_W     = 24;
  localparam int PROD_W     = TOTAL_W + RATE_W + 1;
  localparam int LIFT_SHIFT = 16;

  // stream and config port widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;

  // parameter defaults
  localparam int ANGLE_FRAC_BITS_DEFAULT = 6;
  localparam int COUNT_BITS_DEFAULT      = 8;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DESTROY   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START     = 8'd3;

  // register reset values
  localparam logic                 DIRECTION_RESET = 1'b1;
  localparam logic [DESTROY_W-1:0] DESTROY_RESET   = 21'd46080;
  localparam logic [RATE_W-1:0]    RATE_RESET      = '0;

  typedef struct packed {
    logic                      restart;
    logic signed [ANGLE_W-1:0] angle;
  } restart_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total_angle;
    logic                      limit_free;
    logic                      break_now;
  } track_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mtat_track.sv
`timescale 1ns / 1ps
`default_nettype none

module mtat_track #(
  parameter int ANGLE_FRAC_BITS = mtat_pkg::ANGLE_FRAC_BITS_DEFAULT,
  parameter int COUNT_BITS      = mtat_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic signed [mtat_pkg::ANGLE_W-1:0] angle,
  input  wire logic                               direction_right,
  input  wire logic [mtat_pkg::DESTROY_W-1:0]     destroy_angle,
  input  wire mtat_pkg::restart_t                 restart,
  output mtat_pkg::track_out_t                    result
);
  import mtat_pkg::*;

  localparam int FB = ANGLE_FRAC_BITS;
  localparam int FW = ((ANGLE_W > FB + 9) ? ANGLE_W : FB + 9) + 2;
  localparam int HW = FW + COUNT_BITS + 1;

  localparam logic signed [FW-1:0] ZERO  = '0;
  localparam logic signed [FW-1:0] D30   = FW'(30 << FB);
  localparam logic signed [FW-1:0] D150  = FW'(150 << FB);
  localparam logic signed [FW-1:0] D170  = FW'(170 << FB);
  localparam logic signed [FW-1:0] D180  = FW'(180 << FB);
  localparam logic signed [FW-1:0] D210  = FW'(210 << FB);
  localparam logic signed [FW-1:0] N30   = -D30;
  localparam logic signed [FW-1:0] N150  = -D150;
  localparam logic signed [FW-1:0] N170  = -D170;
  localparam logic signed [FW-1:0] N180  = -D180;

  localparam logic signed [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  localparam logic signed [HW-1:0] TMAX = HW'((1 << (TOTAL_W - 1)) - 1);
  localparam logic signed [HW-1:0] TMIN = -HW'(1 << (TOTAL_W - 1));

  logic signed [ANGLE_W-1:0]    previous_angle;
  logic signed [COUNT_BITS-1:0] half_turns;
  logic                         turning;

  logic signed [FW-1:0]         cur;
  logic signed [FW-1:0]         old;
  logic                         in_range;
  logic                         up;
  logic                         down;
  logic signed [COUNT_BITS-1:0] half_turns_next;
  logic                         turning_next;
  logic signed [FW-1:0]         frac;
  logic signed [HW-1:0]         total_raw;
  logic signed [TOTAL_W-1:0]    total_sat;

  assign cur      = {{(FW-ANGLE_W){angle[ANGLE_W-1]}}, angle};
  assign old      = {{(FW-ANGLE_W){previous_angle[ANGLE_W-1]}}, previous_angle};
  assign in_range = (cur >= N170) && (cur <= D170);

  always_comb begin
    up   = 1'b0;
    down = 1'b0;
    if (direction_right) begin
      if (cur > old) begin
        up = ((cur >= D150 && old < D150) || (cur >= N30 && old < N30)) && turning && in_range;
      end else if (cur < old) begin
        down = ((cur <= D150 && old > D150) || (cur <= N30 && old > N30)) && turning
               && in_range;
      end
    end else begin
      if (cur < old) begin
        up = ((cur <= N150 && old > N150) || (cur <= D30 && old > D30)) && turning && in_range;
      end else if (cur > old) begin
        down = ((cur >= N150 && old < N150) || (cur >= D30 && old < D30)) && turning
               && in_range;
      end
    end

    // saturating half-turn count
    half_turns_next = half_turns;
    if (up && half_turns != CMAX) begin
      half_turns_next = half_turns + COUNT_BITS'(1);
    end else if (down && half_turns != CMIN) begin
      half_turns_next = half_turns - COUNT_BITS'(1);
    end

    // turning flag on zero crossings, cleared only with no half turns left
    turning_next = turning;
    if (direction_right) begin
      if (cur > old && !turning && cur >= ZERO && old < ZERO) begin
        turning_next = 1'b1;
      end else if (cur < old && cur <= ZERO && old > ZERO && half_turns_next == '0) begin
        turning_next = 1'b0;
      end
    end else begin
      if (cur < old && cur <= ZERO && old > ZERO) begin
        turning_next = 1'b1;
      end else if (cur > old && cur >= ZERO && old < ZERO && half_turns_next == '0) begin
        turning_next = 1'b0;
      end
    end

    // fractional part within the current half turn
    frac = ZERO;
    if (direction_right) begin
      if (cur >= N30 && cur <= D180) begin
        frac = cur + D30;
        if (frac >= D180) begin
          frac = frac - D180;
        end
      end else if (turning_next) begin
        frac = D210 + cur;
      end
    end else begin
      if (cur <= D30 && cur >= N180) begin
        frac = D30 - cur;
        if (frac >= D180) begin
          frac = frac - D180;
        end
      end else begin
        frac = D210 - cur;
      end
    end

    total_raw = HW'(frac) + HW'(half_turns_next) * HW'(D180);
    if (total_raw > TMAX) begin
      total_sat = TOTAL_W'(TMAX);
    end else if (total_raw < TMIN) begin
      total_sat = TOTAL_W'(TMIN);
    end else begin
      total_sat = TOTAL_W'(total_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_angle <= '0;
      half_turns     <= '0;
      turning        <= 1'b0;
    end else if (restart.restart) begin
      previous_angle <= restart.angle;
      half_turns     <= '0;
      turning        <= 1'b0;
    end else if (en && in_valid) begin
      previous_angle <= angle;
      half_turns     <= half_turns_next;
      turning        <= turning_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.total_angle <= total_sat;
      result.limit_free  <= turning_next;
      result.break_now   <= $signed({total_sat[TOTAL_W-1], total_sat})
                            >= $signed({2'b00, destroy_angle});
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mtat_lift.sv
`timescale 1ns / 1ps
`default_nettype none

module mtat_lift (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire mtat_pkg::track_out_t           track,
  input  wire logic [mtat_pkg::RATE_W-1:0]    lift_rate,
  output mtat_pkg::track_out_t                result,
  output logic signed [mtat_pkg::LIFT_W-1:0]  lift_target
);
  import mtat_pkg::*;

  logic signed [PROD_W-1:0] product;
  track_out_t               track_q;
  logic signed [PROD_W-1:0] neg_product;

  // negated product, arithmetic shift gives floor rounding
  assign neg_product = -product;

  always_ff @(posedge clk) begin
    if (en) begin
      product     <= PROD_W'($signed(track.total_angle) * $signed({1'b0, lift_rate}));
      track_q     <= track;
      result      <= track_q;
      lift_target <= LIFT_W'(neg_product >>> LIFT_SHIFT);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/multi_turn_angle_tracker.sv
// throughput: one sample per cycle; input register, tracking stage, multiply stage
// and output register advance together and stall only when the output is held
// reset (rst, synchronous, active high): config registers return to their defaults,
// tracking state clears, the pipeline empties
`timescale 1ns / 1ps
`default_nettype none

module multi_turn_angle_tracker #(
  parameter int ANGLE_FRAC_BITS = mtat_pkg::ANGLE_FRAC_BITS_DEFAULT,
  parameter int COUNT_BITS      = mtat_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // sample input: tdata[14:0] swing_angle
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [mtat_pkg::IN_TDATA_W-1:0]     s_tdata,
  // result output: tdata[21:0] total_angle, [53:22] lift_target,
  // [54] limit_free, [55] break_now
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [mtat_pkg::OUT_TDATA_W-1:0]         m_tdata,
  // config write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mtat_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [mtat_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mtat_pkg::*;

  // config registers
  logic                      direction_right;
  logic [DESTROY_W-1:0]      destroy_angle;
  logic [RATE_W-1:0]         lift_rate;
  logic signed [ANGLE_W-1:0] start_angle;

  logic     cfg_write;
  restart_t restart;

  // pipeline valid bits: input register, tracking, multiply, output
  logic v_in;
  logic v_track;
  logic v_mult;
  logic v_out;
  logic en;

  logic signed [ANGLE_W-1:0] angle_q;
  track_out_t                track_res;
  track_out_t                out_res;
  logic signed [LIFT_W-1:0]  lift_target;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // a write of the direction or the start angle restarts tracking
  always_comb begin
    restart.restart = 1'b0;
    restart.angle   = start_angle;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_DIRECTION: restart.restart = 1'b1;
        REG_START: begin
          restart.restart = 1'b1;
          restart.angle   = cfg_data[ANGLE_W-1:0];
        end
        default: restart.restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_right <= DIRECTION_RESET;
      destroy_angle   <= DESTROY_RESET;
      lift_rate       <= RATE_RESET;
      start_angle     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIRECTION: direction_right <= cfg_data[0];
        REG_DESTROY:   destroy_angle   <= cfg_data[DESTROY_W-1:0];
        REG_RATE:      lift_rate       <= cfg_data[RATE_W-1:0];
        REG_START:     start_angle     <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a result is waiting on the output
  assign en       = !v_out || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in    <= 1'b0;
      v_track <= 1'b0;
      v_mult  <= 1'b0;
      v_out   <= 1'b0;
    end else if (en) begin
      v_in    <= s_tvalid;
      v_track <= v_in;
      v_mult  <= v_track;
      v_out   <= v_mult;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s_tvalid) begin
      angle_q <= s_tdata[ANGLE_W-1:0];
    end
  end

  // unwrap stage: owns previous angle, half-turn count and turning flag
  mtat_track #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_track (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (v_in),
    .angle           (angle_q),
    .direction_right (direction_right),
    .destroy_angle   (destroy_angle),
    .restart         (restart),
    .result          (track_res)
  );

  // lift target: registered multiply, then negate and shift into the output register
  mtat_lift u_lift (
    .clk         (clk),
    .en          (en),
    .track       (track_res),
    .lift_rate   (lift_rate),
    .result      (out_res),
    .lift_target (lift_target)
  );

  assign m_tvalid = v_out;
  assign m_tdata  = {out_res.break_now, out_res.limit_free, lift_target, out_res.total_angle};

endmodule

`default_nettype wire

FILE: hw/rtl/mtat_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mtat_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tvalid,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [mtat_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import mtat_pkg::*;

  logic [TOTAL_W-1:0] total_f;
  logic [LIFT_W-1:0]  lift_f;

  assign total_f = m_tdata[TOTAL_W-1:0];
  assign lift_f  = m_tdata[TOTAL_W+LIFT_W-1:TOTAL_W];

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  // pipeline empty after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // input only backs up behind a stalled output
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with output free");

  // rate is unsigned, so the lift never shares the sign of a nonzero total
  a_lift_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !total_f[TOTAL_W-1] |-> lift_f[LIFT_W-1] || lift_f == '0)
    else $error("lift sign wrong for nonnegative total");

  a_lift_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && total_f == '0 |-> lift_f == '0)
    else $error("lift nonzero for zero total");

endmodule

bind multi_turn_angle_tracker mtat_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
